// ===== sv/u8u16_pkg.sv =====
`timescale 1ns / 1ps

package u8u16_pkg;

	// One input transaction: a raw byte and the end-of-string mark.
	typedef struct packed {
		logic [7:0] byte_in;
		logic       last_byte;
	} byte_t;

	// One output transaction: a UTF-16 unit and its flags.
	typedef struct packed {
		logic [15:0] code_unit;
		logic        unit_invalid;
		logic        string_invalid;
		logic        last_unit;
	} unit_t;

	// Decoder control state; everything here is cleared by reset.
	typedef struct packed {
		logic [7:0] held_lead;
		logic       lead_pending;
		logic [1:0] held_count;
		logic       sticky_invalid;
	} ctl_t;

	// Low six bits of the continuation bytes collected so far.
	typedef logic [1:0][5:0] cont_t;

	localparam int MAX_UNITS = 4;
	localparam int CNT_W     = 3;

	localparam logic [1:0]  CONT_TAG  = 2'b10;
	localparam logic [15:0] SUR_HI    = 16'hD800;
	localparam logic [15:0] SUR_LO    = 16'hDC00;
	localparam logic [20:0] SUPP_BASE = 21'h10000;
	localparam logic [10:0] MIN_TWO   = 11'h080;
	localparam logic [15:0] MIN_THREE = 16'h0800;

	// Number of continuation bytes a lead byte asks for; zero if it is no lead.
	function automatic logic [1:0] conts_needed(input logic [7:0] b);
		logic [1:0] need;
		need = 2'd0;
		if (b[7:5] == 3'b110) begin
			need = 2'd1;
		end else if (b[7:4] == 4'b1110) begin
			need = 2'd2;
		end else if (b[7:3] == 5'b11110) begin
			need = 2'd3;
		end
		return need;
	endfunction

endpackage

// ===== sv/utf8_to_utf16_stream_decoder.sv =====
// UTF-8 byte stream in, UTF-16 code units out.
// A unit is offered from the buffer in the cycle after its byte's transaction is accepted.
// Throughput: one byte per cycle while each byte yields at most one unit and the output
// is not stalled; a byte that yields several units (surrogate pair, flushed sequence) holds
// the input while the single-read unit buffer drains one unit per unstalled cycle.
// Reset (arst_n low, asynchronous): no sequence open, buffer empty, sticky flag clear.
`timescale 1ns / 1ps

module utf8_to_utf16_stream_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  u8u16_pkg::byte_t  byte_data,
	output logic              unit_valid,
	input  logic              unit_stall,
	output u8u16_pkg::unit_t  unit_data
);
	import u8u16_pkg::*;

	// Decoder state: control part is reset, held continuations are not.
	ctl_t  ctl_q;
	cont_t cont_q;
	ctl_t  ctl_next;
	cont_t cont_next;

	// Result buffer: units of one input transaction, popped from entry 0.
	unit_t [MAX_UNITS-1:0] units;
	unit_t [MAX_UNITS-1:0] buf_q;
	logic  [CNT_W-1:0]     n_units;
	logic  [CNT_W-1:0]     cnt_q;

	logic in_fire;
	logic out_fire;

	u8u16_decode u_decode (
		.item      (byte_data),
		.ctl       (ctl_q),
		.cont      (cont_q),
		.ctl_next  (ctl_next),
		.cont_next (cont_next),
		.units     (units),
		.n_units   (n_units)
	);

	// The buffer offers whatever it holds; new input is taken only when the
	// buffer is empty or its final unit leaves in this same cycle.
	assign unit_valid = (cnt_q != '0);
	assign unit_data  = buf_q[0];
	assign out_fire   = unit_valid && !unit_stall;
	assign byte_stall = (cnt_q > CNT_W'(1)) || ((cnt_q == CNT_W'(1)) && unit_stall);
	assign in_fire    = byte_valid && !byte_stall;

	// Advance decoder state on every accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (in_fire) begin
			ctl_q <= ctl_next;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cont_q <= cont_next;
		end
	end

	// Unit count: load on accept, count down on each pop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_fire) begin
			cnt_q <= n_units;
		end else if (out_fire) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Unit payload: load all slots on accept, shift toward entry 0 on a pop.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			buf_q <= units;
		end else if (out_fire) begin
			for (int i = 0; i < MAX_UNITS - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
		end
	end

	// Never more units held than one byte can cause.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_UNITS))
		else $error("unit buffer over capacity");

	// A byte is taken only when the buffer is empty or empties in this cycle.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> ((cnt_q == '0) || ((cnt_q == CNT_W'(1)) && out_fire)))
		else $error("byte accepted over pending units");

	// The end of a string always yields a unit and closes every sequence.
	a_last_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && byte_data.last_byte) |=>
		((cnt_q != '0) && !ctl_q.lead_pending && !ctl_q.sticky_invalid))
		else $error("end of string left state open");

	// The last unit of a string is the final one in the buffer.
	a_last_unit_end: assert property (@(posedge clk) disable iff (!arst_n)
		(unit_valid && unit_data.last_unit) |-> (cnt_q == CNT_W'(1)))
		else $error("last unit not at end of buffer");

endmodule

// ===== sv/u8u16_decode.sv =====
`timescale 1ns / 1ps

module u8u16_decode (
	input  u8u16_pkg::byte_t                         item,
	input  u8u16_pkg::ctl_t                          ctl,
	input  u8u16_pkg::cont_t                         cont,
	output u8u16_pkg::ctl_t                          ctl_next,
	output u8u16_pkg::cont_t                         cont_next,
	output u8u16_pkg::unit_t [u8u16_pkg::MAX_UNITS-1:0] units,
	output logic [u8u16_pkg::CNT_W-1:0]              n_units
);
	import u8u16_pkg::*;

	logic [1:0]  need;
	logic [5:0]  c;
	logic        is_cont;
	logic [10:0] cp11;
	logic [15:0] cp16;
	logic [20:0] cp21;
	logic [20:0] v;

	logic [MAX_UNITS-1:0][15:0] code;
	logic [MAX_UNITS-1:0]       inv;
	logic [CNT_W-1:0]           n;

	assign need    = conts_needed(ctl.held_lead);
	assign c       = item.byte_in[5:0];
	assign is_cont = (item.byte_in[7:6] == CONT_TAG);
	assign cp11    = {ctl.held_lead[4:0], c};
	assign cp16    = {ctl.held_lead[3:0], cont[0], c};
	assign cp21    = {ctl.held_lead[2:0], cont[0], cont[1], c};
	assign v       = cp21 - SUPP_BASE;

	always_comb begin
		ctl_next  = ctl;
		cont_next = cont;
		code      = '0;
		inv       = '0;
		n         = '0;

		if (ctl.lead_pending && is_cont && (need != 2'd0)) begin
			if (({1'b0, ctl.held_count} + 3'd1) < {1'b0, need}) begin
				// hold the continuation and wait for more
				cont_next[ctl.held_count[0]] = c;
				ctl_next.held_count = ctl.held_count + 2'd1;
			end else begin
				ctl_next.lead_pending = 1'b0;
				ctl_next.held_count   = 2'd0;
				case (need)
					2'd1: begin
						code[0] = {5'd0, cp11};
						inv[0]  = (cp11 < MIN_TWO);
						n       = 3'd1;
					end
					2'd2: begin
						code[0] = cp16;
						inv[0]  = (cp16 < MIN_THREE);
						n       = 3'd1;
					end
					default: begin
						if (cp21[20:16] == 5'd0) begin
							code[0] = cp21[15:0];
							inv[0]  = 1'b1;
							n       = 3'd1;
						end else begin
							code[0] = SUR_HI | {5'd0, v[20:10]};
							code[1] = SUR_LO | {6'd0, v[9:0]};
							n       = 3'd2;
						end
					end
				endcase
			end
		end else begin
			// drop the open sequence as raw invalid units
			if (ctl.lead_pending) begin
				code[0] = {8'd0, ctl.held_lead};
				inv[0]  = 1'b1;
				n       = 3'd1;
				if (ctl.held_count >= 2'd1) begin
					code[1] = {8'd0, CONT_TAG, cont[0]};
					inv[1]  = 1'b1;
					n       = 3'd2;
				end
				if (ctl.held_count >= 2'd2) begin
					code[2] = {8'd0, CONT_TAG, cont[1]};
					inv[2]  = 1'b1;
					n       = 3'd3;
				end
			end
			ctl_next.lead_pending = 1'b0;
			ctl_next.held_count   = 2'd0;
			// start afresh with this byte
			if (!item.byte_in[7]) begin
				code[n[1:0]] = {8'd0, item.byte_in};
				inv[n[1:0]]  = 1'b0;
				n            = n + 3'd1;
			end else if (conts_needed(item.byte_in) == 2'd0) begin
				code[n[1:0]] = {8'd0, item.byte_in};
				inv[n[1:0]]  = 1'b1;
				n            = n + 3'd1;
			end else begin
				ctl_next.held_lead    = item.byte_in;
				ctl_next.lead_pending = 1'b1;
			end
		end

		// end of string: flush whatever is still open
		if (item.last_byte && ctl_next.lead_pending) begin
			code[n[1:0]] = {8'd0, ctl_next.held_lead};
			inv[n[1:0]]  = 1'b1;
			n            = n + 3'd1;
			if (ctl_next.held_count >= 2'd1) begin
				code[n[1:0]] = {8'd0, CONT_TAG, cont_next[0]};
				inv[n[1:0]]  = 1'b1;
				n            = n + 3'd1;
			end
			if (ctl_next.held_count >= 2'd2) begin
				code[n[1:0]] = {8'd0, CONT_TAG, cont_next[1]};
				inv[n[1:0]]  = 1'b1;
				n            = n + 3'd1;
			end
		end
		if (item.last_byte) begin
			ctl_next.lead_pending = 1'b0;
			ctl_next.held_count   = 2'd0;
		end

		ctl_next.sticky_invalid = ctl.sticky_invalid;
		for (int i = 0; i < MAX_UNITS; i++) begin
			ctl_next.sticky_invalid    = ctl_next.sticky_invalid | inv[i];
			units[i].code_unit         = code[i];
			units[i].unit_invalid      = inv[i];
			units[i].string_invalid    = ctl_next.sticky_invalid;
			units[i].last_unit         = item.last_byte && (CNT_W'(i + 1) == n);
		end
		if (item.last_byte) begin
			ctl_next.sticky_invalid = 1'b0;
		end
		n_units = n;
	end

endmodule
